// ===== sv/rcsw_pkg.sv =====
// Shared types, constants and the cos^2 weight table for the raised-cosine spectrum window.
`default_nettype none

package rcsw_pkg;

    // Field and register widths.
    localparam int MAX_DIM        = 4096;
    localparam int DIM_BITS       = 13;
    localparam int IDX_BITS       = 12;
    localparam int FRAC_BITS      = 4;
    localparam int DIST_BITS      = IDX_BITS + FRAC_BITS;
    localparam int CUTOFF_BITS    = 16;
    localparam int STEP_BITS      = 24;
    localparam int SAMPLE_BITS    = 24;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 24;

    // Phase and table addressing.
    localparam int TABLE_BITS     = 10;
    localparam int TAB_LEN        = (1 << TABLE_BITS) + 1;
    localparam int K_BITS         = TABLE_BITS + 1;
    localparam int PHASE_FRAC     = 28;
    localparam int PHASE_BITS     = DIST_BITS + STEP_BITS;
    localparam int SAT_BITS       = PHASE_FRAC + 1;
    localparam int K_SHIFT        = PHASE_FRAC - TABLE_BITS;
    localparam int K_ROUND        = 1 << (K_SHIFT - 1);
    localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << PHASE_FRAC;

    // The table is read through banks of 256 entries and a final select.
    localparam int BANK_ADDR_BITS = 8;
    localparam int BANK_SEL_BITS  = TABLE_BITS - BANK_ADDR_BITS;
    localparam int NUM_BANKS      = 1 << BANK_SEL_BITS;

    // Weights and scaling.
    localparam int WEIGHT_BITS    = 17;
    localparam logic [WEIGHT_BITS-1:0] ONE_Q16 = WEIGHT_BITS'(65536);
    localparam int WPROD_BITS     = 2 * WEIGHT_BITS;
    localparam int SCALE_SHIFT    = 16;
    localparam int ROUND_HALF     = 1 << (SCALE_SHIFT - 1);
    localparam int MUL_BITS       = SAMPLE_BITS + WEIGHT_BITS + 1;

    // Pipeline depths.
    localparam int AXIS_STAGES    = 6;
    localparam int PIPE_LATENCY   = AXIS_STAGES + 3;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_FRAME_COLS     = 3'd0,
        REG_FRAME_ROWS     = 3'd1,
        REG_CENTER_MODE    = 3'd2,
        REG_COL_CUTOFF     = 3'd3,
        REG_ROW_CUTOFF     = 3'd4,
        REG_COL_PHASE_STEP = 3'd5,
        REG_ROW_PHASE_STEP = 3'd6
    } cfg_reg_t;

    // One input beat.
    typedef struct packed {
        logic        [IDX_BITS-1:0]    row_index;
        logic        [IDX_BITS-1:0]    col_index;
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
    } rcsw_in_t;

    // One result beat.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered_re;
        logic signed [SAMPLE_BITS-1:0] filtered_im;
    } rcsw_out_t;

    // Complex sample carried alongside the weight pipeline.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } rcsw_cplx_t;

    // Per-axis settings handed from the register file to an axis pipeline.
    typedef struct packed {
        logic [DIM_BITS-1:0]    frame_size;
        logic [CUTOFF_BITS-1:0] cutoff;
        logic [STEP_BITS-1:0]   step;
        logic                   center;
    } rcsw_axis_cfg_t;

    typedef logic [WEIGHT_BITS-1:0] wtab_t [TAB_LEN];

    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    // Taylor series denominators (2n-1)*(2n) for n = 1 to 8.
    localparam logic [63:0] TAYLOR_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                               64'd90, 64'd132, 64'd182, 64'd240};

    // Cosine in Q30 by a Taylor series up to z^16/16!, clamped to [0, 1].
    function automatic logic [63:0] cos_q30(input logic [63:0] z);
        logic        [63:0] z2;
        logic        [63:0] term;
        logic signed [63:0] acc;
        z2   = (z * z) >> 30;
        term = ONE_Q30;
        acc  = $signed(ONE_Q30);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * z2) >> 30) / TAYLOR_DIV[n-1];
            if ((n & 1) == 1)
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > $signed(ONE_Q30))
            acc = $signed(ONE_Q30);
        return 64'(acc);
    endfunction

    // The cos^2 table in Q1.16, built as (1 +/- cos z) / 2 and rounded.
    function automatic wtab_t build_wtab();
        wtab_t       t;
        logic [63:0] z;
        logic [63:0] num;
        for (int k = 0; k < TAB_LEN; k++)
        begin
            if (2 * k <= (1 << TABLE_BITS))
            begin
                z   = (PI_Q30 * 64'(k)) >> TABLE_BITS;
                num = ONE_Q30 + cos_q30(z);
            end
            else
            begin
                z   = (PI_Q30 * 64'((1 << TABLE_BITS) - k)) >> TABLE_BITS;
                num = ONE_Q30 - cos_q30(z);
            end
            t[k] = WEIGHT_BITS'((num + 64'd16384) >> 15);
        end
        return t;
    endfunction

    localparam wtab_t WTAB = build_wtab();
    localparam logic [WEIGHT_BITS-1:0] WTAB_LAST = WTAB[TAB_LEN-1];

endpackage

`default_nettype wire

// ===== sv/rcsw_cfg.sv =====
// Configuration register file for the raised-cosine spectrum window.
`default_nettype none

module rcsw_cfg
    import rcsw_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0] wr_index,
    input  wire logic [CFG_DATA_BITS-1:0] wr_data,
    output rcsw_axis_cfg_t                row_cfg,
    output rcsw_axis_cfg_t                col_cfg
);

    logic [DIM_BITS-1:0]    frame_cols_reg, frame_cols_next;
    logic [DIM_BITS-1:0]    frame_rows_reg, frame_rows_next;
    logic                   center_mode_reg, center_mode_next;
    logic [CUTOFF_BITS-1:0] col_cutoff_reg, col_cutoff_next;
    logic [CUTOFF_BITS-1:0] row_cutoff_reg, row_cutoff_next;
    logic [STEP_BITS-1:0]   col_step_reg, col_step_next;
    logic [STEP_BITS-1:0]   row_step_reg, row_step_next;

    // Decode a register write beat.
    always_comb
    begin
        frame_cols_next  = frame_cols_reg;
        frame_rows_next  = frame_rows_reg;
        center_mode_next = center_mode_reg;
        col_cutoff_next  = col_cutoff_reg;
        row_cutoff_next  = row_cutoff_reg;
        col_step_next    = col_step_reg;
        row_step_next    = row_step_reg;
        if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_FRAME_COLS:     frame_cols_next  = wr_data[DIM_BITS-1:0];
                REG_FRAME_ROWS:     frame_rows_next  = wr_data[DIM_BITS-1:0];
                REG_CENTER_MODE:    center_mode_next = wr_data[0];
                REG_COL_CUTOFF:     col_cutoff_next  = wr_data[CUTOFF_BITS-1:0];
                REG_ROW_CUTOFF:     row_cutoff_next  = wr_data[CUTOFF_BITS-1:0];
                REG_COL_PHASE_STEP: col_step_next    = wr_data[STEP_BITS-1:0];
                REG_ROW_PHASE_STEP: row_step_next    = wr_data[STEP_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Registers come out of reset with a 256 by 256 frame and a taper one tenth of the frame wide.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cols_reg  <= DIM_BITS'(256);
            frame_rows_reg  <= DIM_BITS'(256);
            center_mode_reg <= 1'b0;
            col_cutoff_reg  <= CUTOFF_BITS'(1638);
            row_cutoff_reg  <= CUTOFF_BITS'(1638);
            col_step_reg    <= STEP_BITS'(655360);
            row_step_reg    <= STEP_BITS'(655360);
        end
        else
        begin
            frame_cols_reg  <= frame_cols_next;
            frame_rows_reg  <= frame_rows_next;
            center_mode_reg <= center_mode_next;
            col_cutoff_reg  <= col_cutoff_next;
            row_cutoff_reg  <= row_cutoff_next;
            col_step_reg    <= col_step_next;
            row_step_reg    <= row_step_next;
        end
    end

    // Group the settings per axis.
    always_comb
    begin
        row_cfg.frame_size = frame_rows_reg;
        row_cfg.cutoff     = row_cutoff_reg;
        row_cfg.step       = row_step_reg;
        row_cfg.center     = center_mode_reg;
        col_cfg.frame_size = frame_cols_reg;
        col_cfg.cutoff     = col_cutoff_reg;
        col_cfg.step       = col_step_reg;
        col_cfg.center     = center_mode_reg;
    end

endmodule

`default_nettype wire

// ===== sv/rcsw_axis.sv =====
// Six-stage pipeline that turns one axis index into its raised-cosine weight.
`default_nettype none

module rcsw_axis
    import rcsw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [IDX_BITS-1:0]    idx,
    input  wire rcsw_axis_cfg_t         cfg,
    output logic                        weight_valid,
    output logic [WEIGHT_BITS-1:0]      weight
);

    // Valid bits, one per stage.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;

    // Stage 1: distance from zero frequency.
    logic [DIM_BITS-1:0]  n_eff;
    logic [DIM_BITS-1:0]  mirror;
    logic [DIST_BITS-1:0] pos;
    logic [DIST_BITS-1:0] mirror_pos;
    logic [DIST_BITS-1:0] half_next;
    logic [DIST_BITS-1:0] dist_next;
    logic                 outside_next;
    logic [DIST_BITS-1:0] dist_reg;
    logic [DIST_BITS-1:0] half_reg;
    logic                 outside_reg;

    // Stage 2: region flags and offset past the cutoff.
    logic                 one2_next, zero2_next;
    logic [DIST_BITS-1:0] diff_next;
    logic                 one2_reg, zero2_reg;
    logic [DIST_BITS-1:0] diff_reg;

    // Stage 3: phase product.
    logic [PHASE_BITS-1:0] phase_next;
    logic [PHASE_BITS-1:0] phase_reg;
    logic                  one3_reg, zero3_reg;

    // Stage 4: saturated, rounded table address.
    logic [SAT_BITS-1:0] sat;
    logic [K_BITS-1:0]   k_next;
    logic [K_BITS-1:0]   k_reg;
    logic                one4_reg, zero4_reg;

    // Stage 5: bank reads.
    logic [WEIGHT_BITS-1:0]   bank_reg [NUM_BANKS];
    logic [BANK_SEL_BITS-1:0] sel_reg;
    logic                     last_reg;
    logic                     one5_reg, zero5_reg;

    // Stage 6: final weight.
    logic [WEIGHT_BITS-1:0] weight_next;
    logic [WEIGHT_BITS-1:0] weight_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // Stage 1: clamp the frame size and measure the Q12.4 distance.
    always_comb
    begin
        n_eff        = (cfg.frame_size > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM)
                                                             : cfg.frame_size;
        outside_next = {1'b0, idx} >= n_eff;
        pos          = {idx, {FRAC_BITS{1'b0}}};
        half_next    = DIST_BITS'({n_eff, 3'b000});
        mirror       = n_eff - DIM_BITS'(1) - {1'b0, idx};
        mirror_pos   = {mirror[IDX_BITS-1:0], {FRAC_BITS{1'b0}}};
        if (cfg.center)
            dist_next = (pos > half_next) ? (pos - half_next) : (half_next - pos);
        else
            dist_next = (pos < mirror_pos) ? pos : mirror_pos;
    end

    always_ff @(posedge clk)
    begin
        dist_reg    <= dist_next;
        half_reg    <= half_next;
        outside_reg <= outside_next;
    end

    // Stage 2: inside the cutoff the weight is one, past the half frame it is zero.
    always_comb
    begin
        one2_next  = !outside_reg && (dist_reg < cfg.cutoff);
        zero2_next = outside_reg || (dist_reg >= half_reg);
        diff_next  = dist_reg - cfg.cutoff;
    end

    always_ff @(posedge clk)
    begin
        one2_reg  <= one2_next;
        zero2_reg <= zero2_next;
        diff_reg  <= diff_next;
    end

    // Stage 3: phase in quarter-turns, Q12.28.
    always_comb
    begin
        phase_next = PHASE_BITS'(diff_reg) * PHASE_BITS'(cfg.step);
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        one3_reg  <= one2_reg;
        zero3_reg <= zero2_reg;
    end

    // Stage 4: saturate at one quarter-turn and round to the table grid.
    always_comb
    begin
        sat    = (phase_reg > PHASE_ONE) ? SAT_BITS'(PHASE_ONE) : SAT_BITS'(phase_reg);
        k_next = K_BITS'((sat + SAT_BITS'(K_ROUND)) >> K_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        one4_reg  <= one3_reg;
        zero4_reg <= zero3_reg;
    end

    // Stage 5: read every bank at the low address bits.
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        always_ff @(posedge clk)
        begin
            bank_reg[b] <= WTAB[K_BITS'({BANK_SEL_BITS'(b), k_reg[BANK_ADDR_BITS-1:0]})];
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg   <= k_reg[TABLE_BITS-1:BANK_ADDR_BITS];
        last_reg  <= k_reg[TABLE_BITS];
        one5_reg  <= one4_reg;
        zero5_reg <= zero4_reg;
    end

    // Stage 6: pick the bank, the last table entry, or the flat regions.
    always_comb
    begin
        if (one5_reg)
            weight_next = ONE_Q16;
        else if (zero5_reg)
            weight_next = '0;
        else if (last_reg)
            weight_next = WTAB_LAST;
        else
            weight_next = bank_reg[sel_reg];
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
    end

    assign weight_valid = s6_valid_reg;
    assign weight       = weight_reg;

    // The rounded address never runs past the last table entry.
    a_k_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (k_reg <= K_BITS'(TAB_LEN - 1)))
        else $error("table address past the last entry");

    // An index outside the frame ends up as a zero weight, not a unit weight.
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && outside_reg) |=> (zero2_reg && !one2_reg))
        else $error("index outside the frame not flagged as zero weight");

    // Axis weights stay within [0, 1].
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        s6_valid_reg |-> (weight_reg <= ONE_Q16))
        else $error("axis weight above one");

endmodule

`default_nettype wire

// ===== sv/rcsw_scale.sv =====
// Three-stage pipeline that combines the two axis weights and scales the sample.
`default_nettype none

module rcsw_scale
    import rcsw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [WEIGHT_BITS-1:0] row_weight,
    input  wire logic [WEIGHT_BITS-1:0] col_weight,
    input  wire rcsw_cplx_t             sample,
    output logic                        out_valid,
    output rcsw_out_t                   result
);

    logic t1_valid_reg, t2_valid_reg, done_reg;

    // Stage 1: combined weight.
    logic [WPROD_BITS-1:0]  wprod;
    logic [WEIGHT_BITS-1:0] w_next;
    logic [WEIGHT_BITS-1:0] w_reg;
    rcsw_cplx_t             samp_reg;

    // Stage 2: sample products.
    logic signed [MUL_BITS-1:0] re_prod_next, im_prod_next;
    logic signed [MUL_BITS-1:0] re_prod_reg, im_prod_reg;

    // Stage 3: rounded results.
    logic signed [MUL_BITS-1:0] re_sum, im_sum;
    rcsw_out_t                  result_next;
    rcsw_out_t                  result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            t1_valid_reg <= in_valid;
            t2_valid_reg <= t1_valid_reg;
            done_reg     <= t2_valid_reg;
        end
    end

    // Stage 1: product of the axis weights, rounded back to Q1.16.
    always_comb
    begin
        wprod  = WPROD_BITS'(row_weight) * WPROD_BITS'(col_weight);
        w_next = WEIGHT_BITS'((wprod + WPROD_BITS'(ROUND_HALF)) >> SCALE_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        samp_reg <= sample;
    end

    // Stage 2: signed sample times the unsigned weight.
    always_comb
    begin
        re_prod_next = MUL_BITS'(samp_reg.re) * MUL_BITS'($signed({1'b0, w_reg}));
        im_prod_next = MUL_BITS'(samp_reg.im) * MUL_BITS'($signed({1'b0, w_reg}));
    end

    always_ff @(posedge clk)
    begin
        re_prod_reg <= re_prod_next;
        im_prod_reg <= im_prod_next;
    end

    // Stage 3: round half up; the result never exceeds the input magnitude.
    always_comb
    begin
        re_sum                  = re_prod_reg + MUL_BITS'(ROUND_HALF);
        im_sum                  = im_prod_reg + MUL_BITS'(ROUND_HALF);
        result_next.filtered_re = re_sum[SCALE_SHIFT +: SAMPLE_BITS];
        result_next.filtered_im = im_sum[SCALE_SHIFT +: SAMPLE_BITS];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = done_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// ===== sv/raised_cosine_spectrum_window.sv =====
// Top level of the separable raised-cosine spectrum window.
// A beat passes through the six axis stages and then the three scale stages
// before its done strobe is raised.
// Throughput: one beat per clock; the receiver cannot stall, so busy is low
// except in the first cycle after reset.
// Reset clears the valid pipeline and loads the default configuration.
`default_nettype none

module raised_cosine_spectrum_window
    import rcsw_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire rcsw_in_t                 item,
    output logic                          done,
    output rcsw_out_t                     result,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic                   busy_reg;
    logic                   accept;
    rcsw_axis_cfg_t         row_cfg;
    rcsw_axis_cfg_t         col_cfg;
    logic                   row_valid, col_valid;
    logic [WEIGHT_BITS-1:0] row_weight, col_weight;
    rcsw_cplx_t             sample_line_reg [AXIS_STAGES];

    // Busy only for the cycle right after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;
    assign accept    = start && !busy_reg;

    // Configuration registers.
    rcsw_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .row_cfg  (row_cfg),
        .col_cfg  (col_cfg)
    );

    // One weight pipeline per axis.
    rcsw_axis u_row_axis (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .idx          (item.row_index),
        .cfg          (row_cfg),
        .weight_valid (row_valid),
        .weight       (row_weight)
    );

    rcsw_axis u_col_axis (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .idx          (item.col_index),
        .cfg          (col_cfg),
        .weight_valid (col_valid),
        .weight       (col_weight)
    );

    // The sample rides a delay line matched to the axis pipelines.
    always_ff @(posedge clk)
    begin
        sample_line_reg[0].re <= item.sample_re;
        sample_line_reg[0].im <= item.sample_im;
        for (int i = 1; i < AXIS_STAGES; i++)
        begin
            sample_line_reg[i] <= sample_line_reg[i-1];
        end
    end

    // Combine the weights and scale the sample.
    rcsw_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (col_valid),
        .row_weight (row_weight),
        .col_weight (col_weight),
        .sample     (sample_line_reg[AXIS_STAGES-1]),
        .out_valid  (done),
        .result     (result)
    );

    // Every result beat comes from an earlier accepted beat.
    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result beat without a matching input beat");

    // The two axis pipelines stay in lockstep.
    a_axes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid == col_valid)
        else $error("row and column weight pipelines out of step");

    // The block is ready once the busy cycle that follows reset is over.
    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (!busy && cfg_ready))
        else $error("busy after the reset cycle");

endmodule

`default_nettype wire
